// ===== hw/rtl/baag_pkg.sv =====
// baag_pkg: shared types, widths and codes of the blocked array address generator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package baag_pkg;

   localparam int DEF_MAX_DIM   = 4096;
   localparam int DEF_MAX_BLOCK = 256;

   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int SIDE_W     = 9;
   localparam int ADDR_W     = 25;
   localparam int NUM_W      = 14;
   localparam int BLK_W      = NUM_W;
   localparam int IN_W       = SIDE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int DIV_LANES  = 4;
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam int LANE_COL  = 0;
   localparam int LANE_ROW  = 1;
   localparam int LANE_ACR  = 2;
   localparam int LANE_DOWN = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE   = 2'd2;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_SCAN      = 1'b1;

   localparam int SIDE_RESET = 16;

   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] col_in;
      logic [COORD_W-1:0] row_in;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] col_out;
      logic [COORD_W-1:0] row_out;
      logic [ADDR_W-1:0]  address;
      logic               out_of_range;
      logic               scan_last;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [SIDE_W-1:0] side;
   } cfg_type;

   typedef enum logic [1:0] {
      K_XLATE,
      K_XLATE_OOR,
      K_SCAN,
      K_SCAN_EMPTY
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_POSC,
      ST_POSR,
      ST_CHECK,
      ST_T1,
      ST_T2,
      ST_T3,
      ST_DONE
   } bst_type;

endpackage

// ===== hw/rtl/baag_front.sv =====
// baag_front: configuration registers and classification of incoming beats
// depends on baag_pkg; feeds baag_queue
`timescale 1ns / 1ps

module baag_front #(
   parameter int MAX_DIM   = baag_pkg::DEF_MAX_DIM,
   parameter int MAX_BLOCK = baag_pkg::DEF_MAX_BLOCK
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [baag_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [baag_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  baag_pkg::req_type                   req_data,
   input  logic                                q_ready,
   output logic                                q_push,
   output baag_pkg::item_type                  q_item,
   output baag_pkg::cfg_type                   cfg
);

   localparam int SIDE_RST = (MAX_BLOCK < baag_pkg::SIDE_RESET) ? MAX_BLOCK
                                                                 : baag_pkg::SIDE_RESET;

   logic [baag_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [baag_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [baag_pkg::SIDE_W-1:0] side_ff, side_in;
   logic [baag_pkg::DIM_W-1:0]  dim_cap;
   logic [baag_pkg::SIDE_W-1:0] side_cap;
   logic                        oor;

   // effective values are stored at write time
   always_comb begin
      dim_cap = (32'(csr_wdata) > MAX_DIM) ? baag_pkg::DIM_W'(MAX_DIM) : csr_wdata;
      if (csr_wdata[baag_pkg::SIDE_W-1:0] == '0) begin
         side_cap = baag_pkg::SIDE_W'(1);
      end else if (32'(csr_wdata[baag_pkg::SIDE_W-1:0]) > MAX_BLOCK) begin
         side_cap = baag_pkg::SIDE_W'(MAX_BLOCK);
      end else begin
         side_cap = csr_wdata[baag_pkg::SIDE_W-1:0];
      end
      width_in  = width_ff;
      height_in = height_ff;
      side_in   = side_ff;
      if (csr_we) begin
         unique case (csr_index)
            baag_pkg::CSR_WIDTH:  width_in  = dim_cap;
            baag_pkg::CSR_HEIGHT: height_in = dim_cap;
            baag_pkg::CSR_SIDE:   side_in   = side_cap;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         side_ff   <= baag_pkg::SIDE_W'(SIDE_RST);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         side_ff   <= side_in;
      end
   end

   always_comb begin
      cfg.width  = width_ff;
      cfg.height = height_ff;
      cfg.side   = side_ff;
      oor = ({1'b0, req_data.col_in} >= width_ff) || ({1'b0, req_data.row_in} >= height_ff);
      q_item.col = req_data.col_in;
      q_item.row = req_data.row_in;
      if (req_data.opcode == baag_pkg::OP_TRANSLATE) begin
         q_item.kind = oor ? baag_pkg::K_XLATE_OOR : baag_pkg::K_XLATE;
      end else begin
         q_item.kind = (width_ff == '0 || height_ff == '0) ? baag_pkg::K_SCAN_EMPTY
                                                          : baag_pkg::K_SCAN;
      end
      req_ready = q_ready;
      q_push    = req_valid && q_ready;
   end

endmodule

// ===== hw/rtl/baag_queue.sv =====
// baag_queue: two-entry queue of classified beats between front and back
// depends on baag_pkg
`timescale 1ns / 1ps

module baag_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  baag_pkg::item_type push_item,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output baag_pkg::item_type pop_item
);

   baag_pkg::item_type               entry_ff [baag_pkg::Q_DEPTH];
   logic [baag_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [baag_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [baag_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      push_ready = (count_ff != baag_pkg::Q_CNT_W'(baag_pkg::Q_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_item   = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/baag_div.sv =====
// baag_div: four-lane restoring divider sharing one divisor, one quotient bit per cycle
// depends on baag_pkg; used by baag_back
`timescale 1ns / 1ps

module baag_div (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    start,
   input  logic [baag_pkg::DIV_LANES-1:0][baag_pkg::NUM_W-1:0]     num,
   input  logic [baag_pkg::SIDE_W-1:0]                             den,
   output logic                                                    done,
   output logic [baag_pkg::DIV_LANES-1:0][baag_pkg::NUM_W-1:0]     quo,
   output logic [baag_pkg::DIV_LANES-1:0][baag_pkg::SIDE_W-1:0]    rem
);

   logic                                                   busy_ff, busy_in;
   logic                                                   done_ff, done_in;
   logic [baag_pkg::DIV_CNT_W-1:0]                         cnt_ff, cnt_in;
   logic [baag_pkg::SIDE_W-1:0]                            den_ff, den_in;
   logic [baag_pkg::DIV_LANES-1:0][baag_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [baag_pkg::DIV_LANES-1:0][baag_pkg::SIDE_W-1:0]   rem_ff, rem_in;
   logic [baag_pkg::DIV_LANES-1:0][baag_pkg::SIDE_W:0]     rem_sh;
   logic [baag_pkg::DIV_LANES-1:0][baag_pkg::SIDE_W:0]     rem_sub;
   logic [baag_pkg::DIV_LANES-1:0]                         ge;
   logic                                                   last;

   always_comb begin
      last    = (cnt_ff == baag_pkg::DIV_CNT_W'(baag_pkg::NUM_W - 1));
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      for (int l = 0; l < baag_pkg::DIV_LANES; l++) begin
         rem_sh[l]  = {rem_ff[l], quo_ff[l][baag_pkg::NUM_W-1]};
         ge[l]      = (rem_sh[l] >= {1'b0, den_ff});
         rem_sub[l] = rem_sh[l] - {1'b0, den_ff};
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         quo_in  = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         for (int l = 0; l < baag_pkg::DIV_LANES; l++) begin
            quo_in[l] = {quo_ff[l][baag_pkg::NUM_W-2:0], ge[l]};
            rem_in[l] = ge[l] ? rem_sub[l][baag_pkg::SIDE_W-1:0]
                              : rem_sh[l][baag_pkg::SIDE_W-1:0];
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      done = done_ff;
      quo  = quo_ff;
      rem  = rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

// ===== hw/rtl/baag_back.sv =====
// baag_back: sequencer, shared multiply-add, scan position and result register
// depends on baag_pkg and baag_div; drains baag_queue
`timescale 1ns / 1ps

module baag_back (
   input  logic               clock,
   input  logic               reset,
   input  baag_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  baag_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output baag_pkg::rsp_type  rsp_data
);

   localparam int AW      = baag_pkg::ADDR_W;
   localparam int NW      = baag_pkg::NUM_W;
   localparam int IN_W_P1 = baag_pkg::IN_W + 1;

   baag_pkg::bst_type             state_ff, state_in;
   baag_pkg::kind_type            kind_ff, kind_in;
   logic [baag_pkg::COORD_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [baag_pkg::BLK_W-1:0]    bc_ff, bc_in, br_ff, br_in;
   logic [baag_pkg::IN_W-1:0]     ic_ff, ic_in, ir_ff, ir_in;
   logic [NW-1:0]                 across_ff, across_in, down_ff, down_in;
   logic [AW-1:0]                 pos_c_ff, pos_c_in, pos_r_ff, pos_r_in;
   logic [AW-1:0]                 acc_ff, acc_in;
   logic [baag_pkg::BLK_W-1:0]    scan_bc_ff, scan_bc_in, scan_br_ff, scan_br_in;
   logic [baag_pkg::IN_W-1:0]     scan_ic_ff, scan_ic_in, scan_ir_ff, scan_ir_in;
   baag_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                                                   div_start;
   logic                                                   div_done;
   logic [baag_pkg::DIV_LANES-1:0][NW-1:0]                 div_num;
   logic [baag_pkg::DIV_LANES-1:0][NW-1:0]                 div_quo;
   logic [baag_pkg::DIV_LANES-1:0][baag_pkg::SIDE_W-1:0]   div_rem;

   logic [AW-1:0]        mac_a;
   logic [NW-1:0]        mac_m, mac_c;
   logic [AW+NW-1:0]     mac_prod;
   logic [AW-1:0]        mac_sum;
   logic                 rsp_free, stale;
   logic [IN_W_P1-1:0]   ic_nx, ir_nx;
   logic [baag_pkg::BLK_W:0] bc_nx, br_nx;
   logic                 wrap_c, wrap_r, wrap_bc, wrap_br;

   baag_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cfg.side),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // shared multiply-add: a * m + c, low address bits kept
   always_comb begin
      mac_a = acc_ff;
      mac_m = NW'(cfg.side);
      mac_c = NW'(ic_ff);
      unique case (state_ff)
         baag_pkg::ST_POSC: begin
            mac_a = AW'(bc_ff);
            mac_c = NW'(ic_ff);
         end
         baag_pkg::ST_POSR: begin
            mac_a = AW'(br_ff);
            mac_c = NW'(ir_ff);
         end
         baag_pkg::ST_T1: begin
            mac_a = AW'(br_ff);
            mac_m = across_ff;
            mac_c = NW'(bc_ff);
         end
         baag_pkg::ST_T2: begin
            mac_c = NW'(ir_ff);
         end
         default: ;
      endcase
      mac_prod = mac_a * mac_m;
      mac_sum  = mac_prod[AW-1:0] + AW'(mac_c);
   end

   always_comb begin
      div_num[baag_pkg::LANE_COL]  = NW'(q_item.col);
      div_num[baag_pkg::LANE_ROW]  = NW'(q_item.row);
      div_num[baag_pkg::LANE_ACR]  = NW'(cfg.width) + NW'(cfg.side) - 1'b1;
      div_num[baag_pkg::LANE_DOWN] = NW'(cfg.height) + NW'(cfg.side) - 1'b1;

      stale = (ic_ff >= cfg.side) || (ir_ff >= cfg.side) ||
              (pos_c_ff >= AW'(cfg.width)) || (pos_r_ff >= AW'(cfg.height));

      ic_nx   = {1'b0, ic_ff} + 1'b1;
      ir_nx   = {1'b0, ir_ff} + 1'b1;
      bc_nx   = {1'b0, bc_ff} + 1'b1;
      br_nx   = {1'b0, br_ff} + 1'b1;
      wrap_c  = (ic_nx >= {1'b0, cfg.side}) || (pos_c_ff + 1'b1 >= AW'(cfg.width));
      wrap_r  = (ir_nx >= {1'b0, cfg.side}) || (pos_r_ff + 1'b1 >= AW'(cfg.height));
      wrap_bc = (bc_nx >= (baag_pkg::BLK_W + 1)'(across_ff));
      wrap_br = (br_nx >= (baag_pkg::BLK_W + 1)'(down_ff));

      rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bc_in        = bc_ff;
      br_in        = br_ff;
      ic_in        = ic_ff;
      ir_in        = ir_ff;
      across_in    = across_ff;
      down_in      = down_ff;
      pos_c_in     = pos_c_ff;
      pos_r_in     = pos_r_ff;
      acc_in       = acc_ff;
      scan_bc_in   = scan_bc_ff;
      scan_br_in   = scan_br_ff;
      scan_ic_in   = scan_ic_ff;
      scan_ir_in   = scan_ir_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         baag_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               kind_in = q_item.kind;
               col_in  = q_item.col;
               row_in  = q_item.row;
               bc_in   = scan_bc_ff;
               br_in   = scan_br_ff;
               ic_in   = scan_ic_ff;
               ir_in   = scan_ir_ff;
               unique case (q_item.kind)
                  baag_pkg::K_XLATE_OOR,
                  baag_pkg::K_SCAN_EMPTY: state_in = baag_pkg::ST_DONE;
                  baag_pkg::K_XLATE,
                  baag_pkg::K_SCAN: begin
                     div_start = 1'b1;
                     state_in  = baag_pkg::ST_DIV;
                  end
                  default: ;
               endcase
            end
         end
         baag_pkg::ST_DIV: begin
            if (div_done) begin
               across_in = div_quo[baag_pkg::LANE_ACR];
               down_in   = div_quo[baag_pkg::LANE_DOWN];
               if (kind_ff == baag_pkg::K_XLATE) begin
                  bc_in    = div_quo[baag_pkg::LANE_COL];
                  br_in    = div_quo[baag_pkg::LANE_ROW];
                  ic_in    = div_rem[baag_pkg::LANE_COL];
                  ir_in    = div_rem[baag_pkg::LANE_ROW];
                  state_in = baag_pkg::ST_T1;
               end else begin
                  state_in = baag_pkg::ST_POSC;
               end
            end
         end
         baag_pkg::ST_POSC: begin
            pos_c_in = mac_sum;
            state_in = baag_pkg::ST_POSR;
         end
         baag_pkg::ST_POSR: begin
            pos_r_in = mac_sum;
            state_in = baag_pkg::ST_CHECK;
         end
         baag_pkg::ST_CHECK: begin
            // stale position after a config change: restart the scan
            if (stale) begin
               bc_in    = '0;
               br_in    = '0;
               ic_in    = '0;
               ir_in    = '0;
               pos_c_in = '0;
               pos_r_in = '0;
            end
            state_in = baag_pkg::ST_T1;
         end
         baag_pkg::ST_T1: begin
            acc_in   = mac_sum;
            state_in = baag_pkg::ST_T2;
         end
         baag_pkg::ST_T2: begin
            acc_in   = mac_sum;
            state_in = baag_pkg::ST_T3;
         end
         baag_pkg::ST_T3: begin
            acc_in   = mac_sum;
            state_in = baag_pkg::ST_DONE;
         end
         baag_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = baag_pkg::ST_IDLE;
               unique case (kind_ff)
                  baag_pkg::K_XLATE: begin
                     rsp_in.col_out      = col_ff;
                     rsp_in.row_out      = row_ff;
                     rsp_in.address      = acc_ff;
                     rsp_in.out_of_range = 1'b0;
                     rsp_in.scan_last    = 1'b0;
                  end
                  baag_pkg::K_XLATE_OOR: begin
                     rsp_in.col_out      = col_ff;
                     rsp_in.row_out      = row_ff;
                     rsp_in.address      = '0;
                     rsp_in.out_of_range = 1'b1;
                     rsp_in.scan_last    = 1'b0;
                  end
                  baag_pkg::K_SCAN_EMPTY: begin
                     rsp_in.col_out      = '0;
                     rsp_in.row_out      = '0;
                     rsp_in.address      = '0;
                     rsp_in.out_of_range = 1'b1;
                     rsp_in.scan_last    = 1'b1;
                     scan_bc_in          = '0;
                     scan_br_in          = '0;
                     scan_ic_in          = '0;
                     scan_ir_in          = '0;
                  end
                  baag_pkg::K_SCAN: begin
                     rsp_in.col_out      = pos_c_ff[baag_pkg::COORD_W-1:0];
                     rsp_in.row_out      = pos_r_ff[baag_pkg::COORD_W-1:0];
                     rsp_in.address      = acc_ff;
                     rsp_in.out_of_range = 1'b0;
                     rsp_in.scan_last    = wrap_c && wrap_r && wrap_bc && wrap_br;
                     scan_bc_in          = bc_ff;
                     scan_br_in          = br_ff;
                     scan_ir_in          = ir_ff;
                     scan_ic_in          = ic_nx[baag_pkg::IN_W-1:0];
                     if (wrap_c) begin
                        scan_ic_in = '0;
                        scan_ir_in = ir_nx[baag_pkg::IN_W-1:0];
                        if (wrap_r) begin
                           scan_ir_in = '0;
                           scan_bc_in = bc_nx[baag_pkg::BLK_W-1:0];
                           if (wrap_bc) begin
                              scan_bc_in = '0;
                              scan_br_in = wrap_br ? '0 : br_nx[baag_pkg::BLK_W-1:0];
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = baag_pkg::ST_IDLE;
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= baag_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_bc_ff   <= '0;
         scan_br_ff   <= '0;
         scan_ic_ff   <= '0;
         scan_ir_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_bc_ff   <= scan_bc_in;
         scan_br_ff   <= scan_br_in;
         scan_ic_ff   <= scan_ic_in;
         scan_ir_ff   <= scan_ir_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      bc_ff     <= bc_in;
      br_ff     <= br_in;
      ic_ff     <= ic_in;
      ir_ff     <= ir_in;
      across_ff <= across_in;
      down_ff   <= down_in;
      pos_c_ff  <= pos_c_in;
      pos_r_ff  <= pos_r_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
   end

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == baag_pkg::ST_DIV)
      else $error("divider finished outside the divide phase");

   a_oor_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.out_of_range |-> rsp_ff.address == '0)
      else $error("out-of-range beat carries a nonzero address");

   a_tile_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == baag_pkg::ST_T1 |-> bc_ff < across_ff && ic_ff < cfg.side)
      else $error("tile coordinates outside the array before address build");

   a_scan_col_wraps: assert property (@(posedge clock) disable iff (reset)
      state_ff == baag_pkg::ST_DONE && rsp_free && kind_ff == baag_pkg::K_SCAN
      |=> scan_ic_ff < cfg.side)
      else $error("scan column inside tile not wrapped");

endmodule

// ===== hw/rtl/blocked_array_address_generator_unit.sv =====
// Maps (column, row) of a square-tiled array to a flat address, or steps the tile-order
// scan by one element. Translate and scan beats run the 14-step restoring divider (one
// quotient bit per cycle), then the shared multiply-add that builds the address in three
// steps; scan beats first rebuild their position with it. Out-of-range translates and
// scans of an empty array skip both. Items are handled one at a time in order; a
// two-entry queue lets new beats in while the back end works and a finished result
// waits in the output register. Config writes take effect at once and are expected only
// while no beat is in flight. Depends on baag_pkg, baag_front, baag_queue, baag_back.
`timescale 1ns / 1ps

module blocked_array_address_generator_unit #(
   parameter int MAX_DIM   = baag_pkg::DEF_MAX_DIM,
   parameter int MAX_BLOCK = baag_pkg::DEF_MAX_BLOCK
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [baag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [baag_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  baag_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output baag_pkg::rsp_type               rsp_data
);

   baag_pkg::cfg_type  cfg;
   baag_pkg::item_type push_item, pop_item;
   logic               push, push_ready, pop, pop_valid;

   baag_front #(
      .MAX_DIM   (MAX_DIM),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_ready   (push_ready),
      .q_push    (push),
      .q_item    (push_item),
      .cfg       (cfg)
   );

   baag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   baag_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (pop_valid),
      .q_item    (pop_item),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/blocked_array_address_generator_unit_tb.sv =====
// self-checking bench for the tiled array address generator: translate and scan beats
// are checked against an in-bench model of the tile mapping and scan walk
// depends on baag_pkg and blocked_array_address_generator_unit
`timescale 1ns / 1ps

module blocked_array_address_generator_unit_tb;
   import baag_pkg::*;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;

   blocked_array_address_generator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register mirror and scan walk position
   logic [DIM_W-1:0]   map_w    = '0;
   logic [DIM_W-1:0]   map_h    = '0;
   logic [SIDE_W-1:0]  map_side = SIDE_W'(SIDE_RESET);
   logic [COORD_W-1:0] walk_brow = '0;
   logic [COORD_W-1:0] walk_bcol = '0;
   logic [7:0]         walk_irow = '0;
   logic [7:0]         walk_icol = '0;

   req_type req_backlog[$];
   rsp_type mapped_due[$];
   rsp_type rsp_want;
   int      req_gap   = 0;
   int      rsp_stall = 0;
   bit      req_quiet = 1'b0;
   bit      rsp_quiet = 1'b0;
   int      mismatches = 0;

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40)
         $display("mismatch at %0t: %0s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic logic [ADDR_W-1:0] tiled_address(int col, int row, int w, int b);
      longint across, tile, a;
      across = (w + b - 1) / b;
      tile = longint'(row / b) * across + col / b;
      a = tile * b * b + (row % b) * b + col % b;
      return a[ADDR_W-1:0];
   endfunction

   function automatic void walk_home();
      walk_brow = '0;
      walk_bcol = '0;
      walk_irow = '0;
      walk_icol = '0;
   endfunction

   function automatic rsp_type tile_map_step(req_type rq);
      rsp_type r;
      int      w, h, b, col, row, across, down, ncol, nrow, nbc, nbr;
      logic    last;
      w = (map_w > DEF_MAX_DIM) ? DEF_MAX_DIM : map_w;
      h = (map_h > DEF_MAX_DIM) ? DEF_MAX_DIM : map_h;
      b = (map_side == 0) ? 1 : ((map_side > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : map_side);
      r = '0;
      if (rq.opcode == OP_TRANSLATE) begin
         r.col_out = rq.col_in;
         r.row_out = rq.row_in;
         if (rq.col_in >= w || rq.row_in >= h)
            r.out_of_range = 1'b1;
         else
            r.address = tiled_address(rq.col_in, rq.row_in, w, b);
         return r;
      end
      if (w == 0 || h == 0) begin
         walk_home();
         r.out_of_range = 1'b1;
         r.scan_last = 1'b1;
         return r;
      end
      col = walk_bcol * b + walk_icol;
      row = walk_brow * b + walk_irow;
      if (walk_icol >= b || walk_irow >= b || col >= w || row >= h) begin
         walk_home();
         col = 0;
         row = 0;
      end
      r.col_out = col[COORD_W-1:0];
      r.row_out = row[COORD_W-1:0];
      r.address = tiled_address(col, row, w, b);
      ncol = walk_icol + 1;
      nrow = walk_irow;
      nbc  = walk_bcol;
      nbr  = walk_brow;
      last = 1'b0;
      if (ncol >= b || col + 1 >= w) begin
         ncol = 0;
         nrow++;
         if (nrow >= b || row + 1 >= h) begin
            across = (w + b - 1) / b;
            down = (h + b - 1) / b;
            nrow = 0;
            nbc++;
            if (nbc >= across) begin
               nbc = 0;
               nbr++;
               if (nbr >= down) begin
                  nbr = 0;
                  last = 1'b1;
               end
            end
         end
      end
      walk_icol = ncol[7:0];
      walk_irow = nrow[7:0];
      walk_bcol = nbc[COORD_W-1:0];
      walk_brow = nbr[COORD_W-1:0];
      r.scan_last = last;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            mapped_due.push_back(tile_map_step(req_data));
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_data <= req_backlog.pop_front();
               req_valid <= 1'b1;
               req_gap <= req_quiet ? 0 : $urandom_range(0, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mapped_due.size() == 0) begin
               flag_mismatch("beat with nothing due", 32'(rsp_data.address), 32'(0));
            end else begin
               rsp_want = mapped_due.pop_front();
               if (rsp_data.col_out !== rsp_want.col_out)
                  flag_mismatch("col_out", 32'(rsp_data.col_out), 32'(rsp_want.col_out));
               if (rsp_data.row_out !== rsp_want.row_out)
                  flag_mismatch("row_out", 32'(rsp_data.row_out), 32'(rsp_want.row_out));
               if (rsp_data.address !== rsp_want.address)
                  flag_mismatch("address", 32'(rsp_data.address), 32'(rsp_want.address));
               if (rsp_data.out_of_range !== rsp_want.out_of_range)
                  flag_mismatch("out_of_range", 32'(rsp_data.out_of_range),
                                32'(rsp_want.out_of_range));
               if (rsp_data.scan_last !== rsp_want.scan_last)
                  flag_mismatch("scan_last", 32'(rsp_data.scan_last),
                                32'(rsp_want.scan_last));
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               rsp_stall <= rsp_quiet ? 0 : $urandom_range(0, 16);
         end
      end
   end

   function automatic void queue_item(logic op, int col, int row);
      req_type t;
      t.opcode = op;
      t.col_in = col[COORD_W-1:0];
      t.row_in = row[COORD_W-1:0];
      req_backlog.push_back(t);
   endfunction

   task automatic program_array(int w, int h, int b);
      logic [CSR_DATA_W-1:0] side_word;
      side_word = CSR_DATA_W'($urandom);
      side_word[SIDE_W-1:0] = b[SIDE_W-1:0];
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w[CSR_DATA_W-1:0];
      map_w = w[DIM_W-1:0];
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h[CSR_DATA_W-1:0];
      map_h = h[DIM_W-1:0];
      @(posedge clock);
      csr_index <= CSR_SIDE;
      csr_wdata <= side_word;
      map_side = b[SIDE_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || mapped_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      int w, h, b, n, kind, made, ew, eh;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset configuration is an empty array
      @(negedge clock);
      queue_item(OP_TRANSLATE, 0, 0);
      queue_item(OP_SCAN, 12'hfff, 12'hfff);
      wait_drained();

      program_array(37, 23, 5);
      queue_item(OP_TRANSLATE, 0, 0);
      queue_item(OP_TRANSLATE, 36, 22);
      queue_item(OP_TRANSLATE, 37, 0);
      queue_item(OP_TRANSLATE, 0, 23);
      queue_item(OP_TRANSLATE, 12'hfff, 12'hfff);
      repeat (5) queue_item(OP_SCAN, 0, 0);
      wait_drained();

      // stale scan position after the side changes
      program_array(4096, 4096, 1);
      queue_item(OP_TRANSLATE, 12'hfff, 12'hfff);
      queue_item(OP_TRANSLATE, 12'hfff, 0);
      queue_item(OP_SCAN, 0, 0);
      wait_drained();

      // width above the cap, side zero
      program_array(8191, 4096, 0);
      queue_item(OP_TRANSLATE, 12'hfff, 12'hfff);
      queue_item(OP_SCAN, 0, 0);
      wait_drained();

      program_array(4096, 4096, 256);
      queue_item(OP_TRANSLATE, 12'hfff, 12'hfff);
      queue_item(OP_TRANSLATE, 12'h800, 12'h0ff);
      wait_drained();

      // side above the cap, full wrap of a tiny array
      program_array(3, 2, 511);
      repeat (7) queue_item(OP_SCAN, 0, 0);
      wait_drained();

      made = 0;
      while (made < 1400) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            h = (w == 0) ? $urandom_range(0, 12) : 0;
            b = $urandom_range(1, 8);
         end else if (kind == 1) begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
            b = $urandom_range(0, 511);
         end else if (kind == 2) begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 40);
            b = $urandom_range(0, 511);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            b = $urandom_range(1, 6);
         end
         ew = (w > DEF_MAX_DIM) ? DEF_MAX_DIM : w;
         eh = (h > DEF_MAX_DIM) ? DEF_MAX_DIM : h;
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         program_array(w, h, b);
         n = $urandom_range(20, 70);
         repeat (n) begin
            if ($urandom_range(0, 9) < 6)
               queue_item(OP_SCAN, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else if (ew > 0 && eh > 0 && $urandom_range(0, 9) < 7)
               queue_item(OP_TRANSLATE, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
            else
               queue_item(OP_TRANSLATE, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end
         made += n;
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
